@@ hdl/cpfa_pkg.sv @@
// Shared constants and types of the convex polygon fan area block.
`timescale 1ns / 1ps
`default_nettype none
package cpfa_pkg;

	localparam int VERTEX_DEPTH_DEF = 64;
	localparam int MIN_FAN_VERTICES = 3;
	localparam int COORD_W          = 16;
	localparam int AREA_W           = 40;
	localparam int JOB_CNT_W        = 11;

	typedef struct packed {
		logic                 bank;
		logic [JOB_CNT_W-1:0] count;
		logic                 dropped;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

endpackage
`default_nettype wire

@@ hdl/cpfa_vertex_if.sv @@
// Channel that carries one polygon vertex per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface cpfa_vertex_if
	import cpfa_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic                      last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface
`default_nettype wire

@@ hdl/cpfa_result_if.sv @@
// Channel that carries one polygon area result per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface cpfa_result_if
	import cpfa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] twice_area;
	logic              overflow;

	modport source (output valid, output twice_area, output overflow, input ready);
	modport sink (input valid, input twice_area, input overflow, output ready);
endinterface
`default_nettype wire

@@ hdl/cpfa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/cpfa_front.sv @@
// Front end: stores vertices into the current bank and issues a job per polygon.
`timescale 1ns / 1ps
`default_nettype none
module cpfa_front
	import cpfa_pkg::*;
#(
	parameter int MAX_VERTICES = VERTEX_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	cpfa_vertex_if.sink                              vtx,
	input  wire logic                                fifo_full,
	output logic                                     job_push,
	output job_t                                     job,
	input  wire release_t                            rel,
	output logic                                     mem_we,
	output logic [$clog2(MAX_VERTICES):0]            mem_waddr,
	output logic [2*COORD_W-1:0]                     mem_wdata
);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = $clog2(MAX_VERTICES);

	logic             bank_q;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_next;
	logic             accept;
	logic             room;
	logic [CNT_W-1:0] count_next;
	logic             dropped_next;

	assign vtx.ready    = !busy_q[bank_q] && !fifo_full;
	assign accept       = vtx.valid && vtx.ready;
	assign room         = count_q < CNT_W'(MAX_VERTICES);
	assign count_next   = room ? count_q + CNT_W'(1) : count_q;
	assign dropped_next = dropped_q || !room;

	assign mem_we    = accept && room;
	assign mem_waddr = {bank_q, count_q[IDX_W-1:0]};
	assign mem_wdata = {vtx.vertex_x, vtx.vertex_y};

	assign job_push    = accept && vtx.last_vertex;
	assign job.bank    = bank_q;
	assign job.count   = JOB_CNT_W'(count_next);
	assign job.dropped = dropped_next;

	always_comb begin
		busy_next = busy_q;
		if (rel.valid) begin
			busy_next[rel.bank] = 1'b0;
		end
		if (job_push) begin
			busy_next[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= 1'b0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			busy_q    <= '0;
		end else begin
			busy_q <= busy_next;
			if (accept) begin
				if (vtx.last_vertex) begin
					bank_q    <= !bank_q;
					count_q   <= '0;
					dropped_q <= 1'b0;
				end else begin
					count_q   <= count_next;
					dropped_q <= dropped_next;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/cpfa_job_fifo.sv @@
// Two-entry queue of polygon jobs between the front end and the fan walker.
`timescale 1ns / 1ps
`default_nettype none
module cpfa_job_fifo
	import cpfa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      head,
	output logic      empty
);
	job_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign head    = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

@@ hdl/cpfa_back.sv @@
// Fan walker: reads one bank, sums absolute cross products and drives the result.
`timescale 1ns / 1ps
`default_nettype none
module cpfa_back
	import cpfa_pkg::*;
#(
	parameter int MAX_VERTICES = VERTEX_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     fifo_empty,
	input  wire job_t                     job,
	output logic                          job_pop,
	output release_t                      rel,
	output logic [$clog2(MAX_VERTICES):0] mem_raddr,
	input  wire logic [2*COORD_W-1:0]     mem_rdata,
	cpfa_result_if.source                 res
);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	back_state_t state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] issue_q;
	logic             bank_q;
	logic             drop_q;
	logic [AREA_W-1:0] acc_q;

	logic rd_v_s1, rd_first_s1, rd_pair_s1;
	logic v_s2, v_s3;
	logic signed [COORD_W-1:0] lx_q, ly_q;
	logic signed [DIFF_W-1:0]  dx_s2, dy_s2, pdx_s2, pdy_s2;
	logic signed [PROD_W-1:0]  p1_s3, p2_s3;

	logic                      out_valid_q;
	logic [AREA_W-1:0]         out_area_q;
	logic                      out_ovf_q;

	logic                      issuing;
	logic [CNT_W-1:0]          rd_idx;
	logic signed [COORD_W-1:0] rx, ry;
	logic signed [DIFF_W-1:0]  dx, dy;
	logic signed [CROSS_W-1:0] cross_val, cross_abs;
	logic [AREA_W:0]           sum;
	logic                      out_free;
	logic                      drained;

	assign issuing = (state_q == ST_RUN) && (issue_q != n_q);
	assign rd_idx  = (issue_q == '0) ? n_q - CNT_W'(1) : issue_q - CNT_W'(1);
	assign mem_raddr = {bank_q, rd_idx[IDX_W-1:0]};

	assign rx = mem_rdata[2*COORD_W-1:COORD_W];
	assign ry = mem_rdata[COORD_W-1:0];
	assign dx = DIFF_W'(rx) - DIFF_W'(lx_q);
	assign dy = DIFF_W'(ry) - DIFF_W'(ly_q);

	assign cross_val = CROSS_W'(p1_s3) - CROSS_W'(p2_s3);
	assign cross_abs = cross_val[CROSS_W-1] ? -cross_val : cross_val;
	assign sum       = {1'b0, acc_q} + (AREA_W + 1)'(unsigned'(cross_abs[CROSS_W-2:0]));

	assign drained  = (issue_q == n_q) && !rd_v_s1 && !v_s2 && !v_s3;
	assign out_free = !out_valid_q || res.ready;

	assign job_pop   = (state_q == ST_IDLE) && !fifo_empty;
	assign rel.valid = (state_q == ST_DONE) && out_free;
	assign rel.bank  = bank_q;

	assign res.valid      = out_valid_q;
	assign res.twice_area = out_area_q;
	assign res.overflow   = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			issue_q     <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issuing;
			v_s2    <= rd_v_s1 && rd_pair_s1;
			v_s3    <= v_s2;
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!fifo_empty) begin
						n_q     <= CNT_W'(job.count);
						issue_q <= '0;
						if (job.count < JOB_CNT_W'(MIN_FAN_VERTICES)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (issuing) begin
						issue_q <= issue_q + CNT_W'(1);
					end else if (drained) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			bank_q <= job.bank;
			drop_q <= job.dropped;
			acc_q  <= '0;
		end else if (v_s3) begin
			acc_q <= sum[AREA_W] ? {AREA_W{1'b1}} : sum[AREA_W-1:0];
		end
		rd_first_s1 <= issue_q == '0;
		rd_pair_s1  <= issue_q >= CNT_W'(2);
		if (rd_v_s1) begin
			if (rd_first_s1) begin
				lx_q <= rx;
				ly_q <= ry;
			end else begin
				dx_s2  <= dx;
				dy_s2  <= dy;
				pdx_s2 <= dx_s2;
				pdy_s2 <= dy_s2;
			end
		end
		if (v_s2) begin
			p1_s3 <= pdx_s2 * dy_s2;
			p2_s3 <= dx_s2 * pdy_s2;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_area_q <= acc_q;
			out_ovf_q  <= drop_q;
		end
	end
endmodule
`default_nettype wire

@@ hdl/convex_polygon_fan_area.sv @@
// Vertices are accepted one per cycle while the bank being filled is free and the job queue is not full.
// For n >= 3 stored vertices the result follows one RAM read per vertex and a three-stage
// multiply and accumulate pipeline; with fewer than three stored vertices the walk is skipped
// and the result is driven from the done state.
// Two vertex banks let the next polygon load while the previous one is walked.
// Reset clears the vertex count, the drop flag, the job queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module convex_polygon_fan_area
	import cpfa_pkg::*;
#(
	parameter int MAX_VERTICES = VERTEX_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	cpfa_vertex_if.sink   vtx,
	cpfa_result_if.source res
);
	localparam int ADDR_W = $clog2(MAX_VERTICES) + 1;

	logic                fifo_full;
	logic                fifo_empty;
	logic                job_push;
	logic                job_pop;
	job_t                push_job;
	job_t                head_job;
	release_t            rel;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [2*COORD_W-1:0] mem_wdata;
	logic [2*COORD_W-1:0] mem_rdata;

	cpfa_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.fifo_full (fifo_full),
		.job_push  (job_push),
		.job       (push_job),
		.rel       (rel),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	cpfa_ram #(.WIDTH(2 * COORD_W), .DEPTH(2 ** ADDR_W)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cpfa_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (fifo_full),
		.pop      (job_pop),
		.head     (head_job),
		.empty    (fifo_empty)
	);

	cpfa_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.job        (head_job),
		.job_pop    (job_pop),
		.rel        (rel),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res        (res)
	);
endmodule
`default_nettype wire
